// File: hdl/ffca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types, codes and defaults of the first-fit coalescing allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int DEF_MAX_FREE_EXTENTS = 64;
    localparam int DEF_MAX_LIVE_BLOCKS  = 64;
    localparam int DEF_HEADER_BYTES     = 16;

    localparam logic [31:0] REGION_RESET = 32'd65536;
    localparam logic [7:0]  CHUNK_RESET  = 8'd32;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_RELEASED = 3'd1;
    localparam logic [2:0] ST_NO_MEM   = 3'd2;
    localparam logic [2:0] ST_OUTSIDE  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_REGION = 1'b0;
    localparam logic CFG_CHUNK  = 1'b1;

    // One table entry: a free extent or a live block.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_extent;

endpackage
`default_nettype wire

// File: hdl/ffca_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/first_fit_coalescing_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// First-fit allocator over a byte region with an address-ordered free table
// that merges released blocks with their neighbours.
// ----------------------------------------------------------------------------
// Usage: raise start with an operation while busy is low; the request is
// taken at that edge, and busy rises unless the request is answered from
// idle. The single result appears on o_payload_offset and o_status for one
// cycle marked by o_done, and busy falls in that same cycle. There is no
// back-pressure on the result side. An allocate rounds the size up to the
// chunk (one remainder bit a cycle), then scans the free extents in order,
// and moves extents down when an exact fit removes an extent. A release
// steps past empty live slots and reads each occupied one, scans the free
// extents, and moves extents on insert or merge. Region reset, the unused
// operation and requests refused before any table is read (no free live
// slot, offset outside the region) are answered from idle. The free and
// used tables sit in single-read-port RAMs, so scans and moves go entry by
// entry. After reset the block writes the initial free extent with busy
// high. Configuration writes land at once, whether busy or not.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator #(
    parameter int MAX_FREE_EXTENTS = ffca_pkg::DEF_MAX_FREE_EXTENTS,
    parameter int MAX_LIVE_BLOCKS  = ffca_pkg::DEF_MAX_LIVE_BLOCKS,
    parameter int HEADER_BYTES     = ffca_pkg::DEF_HEADER_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_request_bytes,
    input  wire logic [7:0]  i_align_bytes,
    input  wire logic [31:0] i_block_offset,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output      logic        o_done,
    output      logic [31:0] o_payload_offset,
    output      logic [2:0]  o_status
);
    import ffca_pkg::*;

    localparam int FAW = $clog2(MAX_FREE_EXTENTS);
    localparam int FCW = $clog2(MAX_FREE_EXTENTS + 1);
    localparam int UAW = $clog2(MAX_LIVE_BLOCKS);
    localparam int UCW = $clog2(MAX_LIVE_BLOCKS + 1);
    localparam int NW  = 34;
    localparam logic [NW-1:0]  HDR   = NW'(HEADER_BYTES);
    localparam logic [FCW-1:0] FMAX  = FCW'(MAX_FREE_EXTENTS);
    localparam logic [UCW-1:0] UMAX  = UCW'(MAX_LIVE_BLOCKS);
    localparam logic [5:0]     NLAST = 6'(NW - 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INIT      = 4'd1;
    localparam logic [3:0] S_ROUND     = 4'd2;
    localparam logic [3:0] S_ASCAN_RD  = 4'd3;
    localparam logic [3:0] S_ASCAN_CHK = 4'd4;
    localparam logic [3:0] S_DOWN_RD   = 4'd5;
    localparam logic [3:0] S_DOWN_WR   = 4'd6;
    localparam logic [3:0] S_UFIND_RD  = 4'd7;
    localparam logic [3:0] S_UFIND_CHK = 4'd8;
    localparam logic [3:0] S_FSCAN_RD  = 4'd9;
    localparam logic [3:0] S_FSCAN_CHK = 4'd10;
    localparam logic [3:0] S_MERGE     = 4'd11;
    localparam logic [3:0] S_UP_RD     = 4'd12;
    localparam logic [3:0] S_UP_WR     = 4'd13;

    logic [3:0]           r_state, n_state;
    logic [FCW-1:0]       r_count, n_count;
    logic [FCW-1:0]       r_idx, n_idx;
    logic [FCW-1:0]       r_pos, n_pos;
    logic [UCW-1:0]       r_uidx, n_uidx;
    logic [UAW-1:0]       r_slot, n_slot;
    logic [MAX_LIVE_BLOCKS-1:0] r_valid, n_valid;
    logic                 r_is_alloc, n_is_alloc;
    logic [NW-1:0]        r_shift, n_shift;
    logic [NW-1:0]        r_t, n_t;
    logic [7:0]           r_rem, n_rem;
    logic [5:0]           r_bit, n_bit;
    logic [31:0]          r_s, n_s;
    logic [31:0]          r_len, n_len;
    logic [31:0]          r_off, n_off;
    t_extent              r_prev, n_prev;
    t_extent              r_next, n_next;
    logic [31:0]          r_region;
    logic [7:0]           r_chunk;
    logic                 n_done;
    logic [31:0]          n_payload;
    logic [2:0]           n_status;

    logic                 f_we;
    logic [FAW-1:0]       f_waddr, f_raddr;
    t_extent              f_wdata, f_rdata;
    logic                 u_we;
    logic [UAW-1:0]       u_raddr;
    t_extent              u_wdata, u_rdata;

    logic [UAW-1:0]       free_slot;
    logic                 slot_avail;
    logic [8:0]           div_c, div_tmp;
    logic [7:0]           rem_new;
    logic [NW-1:0]        need;
    logic                 mp, mn;

    ffca_ram #(.WIDTH($bits(t_extent)), .DEPTH(MAX_FREE_EXTENTS)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (f_we),
        .i_waddr(f_waddr),
        .i_wdata(f_wdata),
        .i_raddr(f_raddr),
        .o_rdata(f_rdata)
    );

    ffca_ram #(.WIDTH($bits(t_extent)), .DEPTH(MAX_LIVE_BLOCKS)) u_used_ram (
        .i_clk  (i_clk),
        .i_we   (u_we),
        .i_waddr(r_slot),
        .i_wdata(u_wdata),
        .i_raddr(u_raddr),
        .o_rdata(u_rdata)
    );

    // Lowest free live-block slot.
    always_comb begin
        free_slot  = '0;
        slot_avail = 1'b0;
        for (int k = MAX_LIVE_BLOCKS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_slot  = UAW'(k);
                slot_avail = 1'b1;
            end
        end
    end

    assign need    = {2'b00, i_request_bytes} + {26'd0, i_align_bytes} + HDR;
    assign div_c   = (r_chunk == 8'd0) ? 9'd1 : {1'b0, r_chunk};
    assign div_tmp = {r_rem, r_shift[NW-1]};
    assign rem_new = (div_tmp >= div_c) ? 8'(div_tmp - div_c) : div_tmp[7:0];

    assign mp = (r_pos != '0) &&
                (({1'b0, r_prev.start} + {1'b0, r_prev.len}) == {1'b0, r_s});
    assign mn = (r_pos != r_count) &&
                (({1'b0, r_s} + {1'b0, r_len}) == {1'b0, r_next.start});

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_uidx     = r_uidx;
        n_slot     = r_slot;
        n_valid    = r_valid;
        n_is_alloc = r_is_alloc;
        n_shift    = r_shift;
        n_t        = r_t;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_s        = r_s;
        n_len      = r_len;
        n_off      = r_off;
        n_prev     = r_prev;
        n_next     = r_next;
        n_done     = 1'b0;
        n_payload  = '0;
        n_status   = ST_GRANTED;
        f_we       = 1'b0;
        f_waddr    = '0;
        f_wdata    = '0;
        f_raddr    = r_idx[FAW-1:0];
        u_we       = 1'b0;
        u_wdata    = '0;
        u_raddr    = r_uidx[UAW-1:0];

        case (r_state)
            S_INIT: begin
                f_we    = 1'b1;
                f_wdata = '{start: 32'd0, len: REGION_RESET};
                n_count = FCW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_is_alloc = (i_operation == OP_ALLOC);
                    n_idx      = '0;
                    n_uidx     = '0;
                    case (i_operation)
                        OP_ALLOC: begin
                            if (!slot_avail) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_slot  = free_slot;
                                n_shift = need;
                                n_t     = need;
                                n_rem   = '0;
                                n_bit   = '0;
                                n_state = S_ROUND;
                            end
                        end
                        OP_RELEASE: begin
                            if (i_block_offset >= r_region) begin
                                n_done   = 1'b1;
                                n_status = ST_OUTSIDE;
                            end else begin
                                n_off   = i_block_offset;
                                n_state = S_UFIND_RD;
                            end
                        end
                        OP_RESET: begin
                            n_valid  = '0;
                            n_done   = 1'b1;
                            n_status = ST_RELEASED;
                            if (r_region != 32'd0) begin
                                f_we    = 1'b1;
                                f_wdata = '{start: 32'd0, len: r_region};
                                n_count = FCW'(1);
                            end else begin
                                n_count = '0;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_OUTSIDE;
                        end
                    endcase
                end
            end
            S_ROUND: begin
                // Restoring remainder, one bit of the size a cycle.
                n_rem   = rem_new;
                n_shift = {r_shift[NW-2:0], 1'b0};
                n_bit   = r_bit + 6'd1;
                if (r_bit == NLAST) begin
                    if (rem_new != 8'd0) begin
                        n_t = r_t + NW'(div_c) - NW'(rem_new);
                    end
                    n_state = S_ASCAN_RD;
                end
            end
            S_ASCAN_RD: begin
                if (r_idx == r_count) begin
                    n_done   = 1'b1;
                    n_status = ST_NO_MEM;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_ASCAN_CHK;
                end
            end
            S_ASCAN_CHK: begin
                if ({2'b00, f_rdata.len} >= r_t) begin
                    u_we    = 1'b1;
                    u_wdata = '{start: f_rdata.start, len: r_t[31:0]};
                    n_s     = f_rdata.start;
                    if ({2'b00, f_rdata.len} == r_t) begin
                        n_idx   = r_idx + FCW'(1);
                        n_state = S_DOWN_RD;
                    end else begin
                        f_we      = 1'b1;
                        f_waddr   = r_idx[FAW-1:0];
                        f_wdata   = '{start: f_rdata.start + r_t[31:0],
                                      len:   f_rdata.len - r_t[31:0]};
                        n_valid[r_slot] = 1'b1;
                        n_done    = 1'b1;
                        n_payload = f_rdata.start + HDR[31:0];
                        n_status  = ST_GRANTED;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_idx   = r_idx + FCW'(1);
                    n_state = S_ASCAN_RD;
                end
            end
            S_DOWN_RD: begin
                // Close the gap: entries above the removed one move down.
                if (r_idx == r_count) begin
                    n_count = r_count - FCW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_is_alloc) begin
                        n_valid[r_slot] = 1'b1;
                        n_payload = r_s + HDR[31:0];
                        n_status  = ST_GRANTED;
                    end else begin
                        n_valid[r_slot] = 1'b0;
                        n_status  = ST_RELEASED;
                    end
                end else begin
                    n_state = S_DOWN_WR;
                end
            end
            S_DOWN_WR: begin
                f_we    = 1'b1;
                f_waddr = FAW'(r_idx - FCW'(1));
                f_wdata = f_rdata;
                n_idx   = r_idx + FCW'(1);
                n_state = S_DOWN_RD;
            end
            S_UFIND_RD: begin
                if (r_uidx == UMAX) begin
                    n_done   = 1'b1;
                    n_status = ST_UNKNOWN;
                    n_state  = S_IDLE;
                end else if (!r_valid[r_uidx[UAW-1:0]]) begin
                    n_uidx = r_uidx + UCW'(1);
                end else begin
                    n_state = S_UFIND_CHK;
                end
            end
            S_UFIND_CHK: begin
                if (({1'b0, u_rdata.start} + HDR[32:0]) == {1'b0, r_off}) begin
                    n_slot  = r_uidx[UAW-1:0];
                    n_s     = u_rdata.start;
                    n_len   = u_rdata.len;
                    n_idx   = '0;
                    n_state = S_FSCAN_RD;
                end else begin
                    n_uidx  = r_uidx + UCW'(1);
                    n_state = S_UFIND_RD;
                end
            end
            S_FSCAN_RD: begin
                if (r_idx == r_count) begin
                    n_pos   = r_count;
                    n_state = S_MERGE;
                end else begin
                    n_state = S_FSCAN_CHK;
                end
            end
            S_FSCAN_CHK: begin
                if (f_rdata.start > r_s) begin
                    n_next  = f_rdata;
                    n_pos   = r_idx;
                    n_state = S_MERGE;
                end else begin
                    n_prev  = f_rdata;
                    n_idx   = r_idx + FCW'(1);
                    n_state = S_FSCAN_RD;
                end
            end
            S_MERGE: begin
                if (mp && mn) begin
                    f_we    = 1'b1;
                    f_waddr = FAW'(r_pos - FCW'(1));
                    f_wdata = '{start: r_prev.start,
                                len:   r_prev.len + r_len + r_next.len};
                    n_idx   = r_pos + FCW'(1);
                    n_state = S_DOWN_RD;
                end else if (mp || mn) begin
                    f_we    = 1'b1;
                    if (mp) begin
                        f_waddr = FAW'(r_pos - FCW'(1));
                        f_wdata = '{start: r_prev.start, len: r_prev.len + r_len};
                    end else begin
                        f_waddr = r_pos[FAW-1:0];
                        f_wdata = '{start: r_s, len: r_next.len + r_len};
                    end
                    n_valid[r_slot] = 1'b0;
                    n_done   = 1'b1;
                    n_status = ST_RELEASED;
                    n_state  = S_IDLE;
                end else if (r_count >= FMAX) begin
                    n_done   = 1'b1;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = r_count;
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                // Open a gap at the insert position, moving entries up.
                if (r_idx == r_pos) begin
                    f_we     = 1'b1;
                    f_waddr  = r_pos[FAW-1:0];
                    f_wdata  = '{start: r_s, len: r_len};
                    n_count  = r_count + FCW'(1);
                    n_valid[r_slot] = 1'b0;
                    n_done   = 1'b1;
                    n_status = ST_RELEASED;
                    n_state  = S_IDLE;
                end else begin
                    f_raddr = FAW'(r_idx - FCW'(1));
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                f_we    = 1'b1;
                f_waddr = r_idx[FAW-1:0];
                f_wdata = f_rdata;
                n_idx   = r_idx - FCW'(1);
                n_state = S_UP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_count  <= '0;
            r_valid  <= '0;
            r_region <= REGION_RESET;
            r_chunk  <= CHUNK_RESET;
            o_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            o_done  <= n_done;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_REGION) begin
                    r_region <= i_cfg_data;
                end else begin
                    r_chunk <= i_cfg_data[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx            <= n_idx;
        r_pos            <= n_pos;
        r_uidx           <= n_uidx;
        r_slot           <= n_slot;
        r_is_alloc       <= n_is_alloc;
        r_shift          <= n_shift;
        r_t              <= n_t;
        r_rem            <= n_rem;
        r_bit            <= n_bit;
        r_s              <= n_s;
        r_len            <= n_len;
        r_off            <= n_off;
        r_prev           <= n_prev;
        r_next           <= n_next;
        o_payload_offset <= n_payload;
        o_status         <= n_status;
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FMAX)
        else $error("free extent count above table size");
    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) || $past(start))
        else $error("result without a request in progress");
    a_grant_marks_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_GRANTED |->
            $countones(r_valid) == $countones($past(r_valid)) + 1)
        else $error("grant did not claim exactly one live slot");
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_GRANTED |-> o_payload_offset == 32'd0)
        else $error("payload offset given without a grant");
`endif

endmodule
`default_nettype wire

// File: sim/first_fit_coalescing_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_tb
// Drives allocate, release, region reset and unused commands into the
// allocator. A local copy of the free-extent and live-block tables predicts
// every answer; each result is checked against the oldest outstanding one.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_tb;
    import ffca_pkg::*;

    localparam int NFREE = DEF_MAX_FREE_EXTENTS;
    localparam int NLIVE = DEF_MAX_LIVE_BLOCKS;
    localparam int HDR   = DEF_HEADER_BYTES;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] req;
        logic [7:0]  align;
        logic [31:0] off;
        bit          pick_live;   // resolve the offset from a live block at send time
        bit          drain_first; // wait until every answer is in before sending
    } t_alloc_cmd;

    typedef struct {
        logic [31:0] offset;
        logic [2:0]  status;
    } t_alloc_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = OP_ALLOC;
    logic [31:0] i_request_bytes = '0;
    logic [7:0]  i_align_bytes = '0;
    logic [31:0] i_block_offset = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_REGION;
    logic [31:0] i_cfg_data = '0;
    logic        o_done;
    logic [31:0] o_payload_offset;
    logic [2:0]  o_status;

    first_fit_coalescing_allocator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_request_bytes(i_request_bytes),
        .i_align_bytes(i_align_bytes), .i_block_offset(i_block_offset),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_payload_offset(o_payload_offset), .o_status(o_status)
    );

    always #6 i_clk = ~i_clk;

    t_alloc_cmd    pending_cmds[$];
    t_alloc_answer expected_answers[$];
    t_alloc_cmd    cur_cmd;
    int            idle_pct = 0;
    int            mismatches = 0;

    // Predicted allocator state.
    logic [31:0] region_cfg = REGION_RESET;
    logic [7:0]  chunk_cfg  = CHUNK_RESET;
    logic [31:0] free_base[NFREE];
    logic [31:0] free_len[NFREE];
    int          free_cnt;
    logic [31:0] live_base[NLIVE];
    logic [31:0] live_len[NLIVE];
    bit          live_on[NLIVE];

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    task automatic rebuild_region();
        foreach (live_on[k]) live_on[k] = 1'b0;
        free_cnt = 0;
        if (region_cfg != 0) begin
            free_base[0] = '0;
            free_len[0] = region_cfg;
            free_cnt = 1;
        end
    endtask

    task automatic drop_extent(input int pos);
        for (int k = pos; k + 1 < free_cnt; k++) begin
            free_base[k] = free_base[k + 1];
            free_len[k] = free_len[k + 1];
        end
        free_cnt--;
    endtask

    task automatic predict_alloc(input t_alloc_cmd c, output t_alloc_answer a);
        longint unsigned gran, need, rounded;
        int slot, pos;
        logic [31:0] base;
        gran = (chunk_cfg == 0) ? 1 : chunk_cfg;
        need = longint'(c.req) + longint'(c.align) + HDR;
        rounded = ((need + gran - 1) / gran) * gran;
        a.offset = '0;
        slot = NLIVE;
        for (int k = NLIVE - 1; k >= 0; k--) if (!live_on[k]) slot = k;
        if (slot == NLIVE) begin
            a.status = ST_FULL;
            return;
        end
        pos = free_cnt;
        for (int k = free_cnt - 1; k >= 0; k--)
            if (longint'(free_len[k]) >= rounded) pos = k;
        if (pos == free_cnt) begin
            a.status = ST_NO_MEM;
            return;
        end
        base = free_base[pos];
        if (longint'(free_len[pos]) == rounded) drop_extent(pos);
        else begin
            free_base[pos] = base + rounded[31:0];
            free_len[pos] = free_len[pos] - rounded[31:0];
        end
        live_on[slot] = 1'b1;
        live_base[slot] = base;
        live_len[slot] = rounded[31:0];
        a.offset = base + HDR;
        a.status = ST_GRANTED;
    endtask

    task automatic predict_release(input logic [31:0] off, output t_alloc_answer a);
        int slot, pos;
        longint unsigned s, len;
        bit join_prev, join_next;
        a.offset = '0;
        if (off >= region_cfg) begin
            a.status = ST_OUTSIDE;
            return;
        end
        slot = NLIVE;
        for (int k = NLIVE - 1; k >= 0; k--)
            if (live_on[k] && longint'(live_base[k]) + HDR == longint'(off)) slot = k;
        if (slot == NLIVE) begin
            a.status = ST_UNKNOWN;
            return;
        end
        s = live_base[slot];
        len = live_len[slot];
        pos = free_cnt;
        for (int k = free_cnt - 1; k >= 0; k--) if (longint'(free_base[k]) > s) pos = k;
        join_prev = pos > 0 && longint'(free_base[pos - 1]) + longint'(free_len[pos - 1]) == s;
        join_next = pos < free_cnt && s + len == longint'(free_base[pos]);
        if (join_prev && join_next) begin
            free_len[pos - 1] = free_len[pos - 1] + len[31:0] + free_len[pos];
            drop_extent(pos);
        end else if (join_prev) begin
            free_len[pos - 1] = free_len[pos - 1] + len[31:0];
        end else if (join_next) begin
            free_base[pos] = s[31:0];
            free_len[pos] = free_len[pos] + len[31:0];
        end else begin
            if (free_cnt >= NFREE) begin
                a.status = ST_FULL;
                return;
            end
            for (int k = free_cnt; k > pos; k--) begin
                free_base[k] = free_base[k - 1];
                free_len[k] = free_len[k - 1];
            end
            free_base[pos] = s[31:0];
            free_len[pos] = len[31:0];
            free_cnt++;
        end
        live_on[slot] = 1'b0;
        a.status = ST_RELEASED;
    endtask

    task automatic predict_command(input t_alloc_cmd c);
        t_alloc_answer a;
        a.offset = '0;
        case (c.op)
            OP_ALLOC:   predict_alloc(c, a);
            OP_RELEASE: predict_release(c.off, a);
            OP_RESET: begin
                rebuild_region();
                a.status = ST_RELEASED;
            end
            default:    a.status = ST_OUTSIDE;
        endcase
        expected_answers.push_back(a);
    endtask

    // Driver: a command is transferred at an edge with start high and busy low.
    always @(posedge i_clk) begin
        t_alloc_cmd c;
        int live_idx[$];
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_command(cur_cmd);
            if (!(start && busy)) begin
                if (pending_cmds.size() != 0
                        && !(pending_cmds[0].drain_first && expected_answers.size() != 0)
                        && $urandom_range(99) >= idle_pct) begin
                    c = pending_cmds.pop_front();
                    if (c.pick_live) begin
                        live_idx.delete();
                        foreach (live_on[k]) if (live_on[k]) live_idx.push_back(k);
                        if (live_idx.size() != 0)
                            c.off = live_base[live_idx[$urandom_range(live_idx.size() - 1)]] + HDR;
                    end
                    cur_cmd = c;
                    i_operation <= c.op;
                    i_request_bytes <= c.req;
                    i_align_bytes <= c.align;
                    i_block_offset <= c.off;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so each strobe is checked at once.
    always @(posedge i_clk) begin
        t_alloc_answer e;
        if (i_rst_n && o_done) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("result transfer with no answer outstanding");
            end else begin
                e = expected_answers.pop_front();
                if (o_payload_offset !== e.offset)
                    report_mismatch($sformatf("payload offset %h, wanted %h",
                                              o_payload_offset, e.offset));
                if (o_status !== e.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", o_status, e.status));
            end
        end
    end

    task automatic add_cmd(input logic [1:0] op, input logic [31:0] req,
                           input logic [7:0] align, input logic [31:0] off,
                           input bit pick_live = 1'b0, input bit drain_first = 1'b0);
        t_alloc_cmd c;
        c.op = op;
        c.req = req;
        c.align = align;
        c.off = off;
        c.pick_live = pick_live;
        c.drain_first = drain_first;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || start || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx == CFG_REGION) region_cfg = data;
        else chunk_cfg = data[7:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_random(input int n, input int alloc_pct);
        int r;
        logic [31:0] req;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            case ($urandom_range(19))
                0:       req = $urandom();
                1, 2:    req = $urandom_range(4000);
                default: req = $urandom_range(300);
            endcase
            if (r < alloc_pct)
                add_cmd(OP_ALLOC, req, 8'($urandom_range(255)), $urandom(), 1'b0,
                        $urandom_range(49) == 0);
            else if (r < 97)
                add_cmd(OP_RELEASE, $urandom(), 8'($urandom_range(255)),
                        ($urandom_range(3) == 0) ? $urandom() : region_cfg - 1,
                        $urandom_range(9) != 0);
            else if (r < 99)
                add_cmd(OP_RESET, $urandom(), 8'($urandom_range(255)), $urandom());
            else
                add_cmd(OP_UNUSED, $urandom(), 8'($urandom_range(255)), $urandom());
        end
    endtask

    task automatic run_phase(input logic [31:0] region, input logic [7:0] chunk,
                             input int idle, input int n, input int alloc_pct);
        wait_quiet();
        write_reg(CFG_REGION, region);
        write_reg(CFG_CHUNK, chunk);
        idle_pct = idle;
        add_cmd(OP_RESET, '0, '0, '0);
        add_random(n, alloc_pct);
    endtask

    initial begin
        rebuild_region();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, exact fit, next and two-sided merges, no-memory, outside, unknown.
        add_cmd(OP_ALLOC, 32'd0, 8'd0, '0);
        add_cmd(OP_ALLOC, 32'hFFFF_FFFF, 8'hFF, '0);
        add_cmd(OP_ALLOC, 32'd100, 8'hFF, '0);
        add_cmd(OP_RELEASE, '0, '0, 32'd16);
        add_cmd(OP_RELEASE, '0, '0, 32'd16);
        add_cmd(OP_RELEASE, '0, '0, 32'd65536);
        add_cmd(OP_RELEASE, '0, '0, 32'hFFFF_FFFF);
        add_cmd(OP_UNUSED, '0, '0, '0);
        add_cmd(OP_RESET, '0, '0, '0);
        add_cmd(OP_ALLOC, 32'd65536 - HDR, 8'd0, '0);
        add_cmd(OP_ALLOC, 32'd0, 8'd0, '0);
        add_cmd(OP_RELEASE, '0, '0, 32'd16);
        add_cmd(OP_ALLOC, 32'd16, 8'd0, '0);
        add_cmd(OP_ALLOC, 32'd16, 8'd0, '0);
        add_cmd(OP_ALLOC, 32'd16, 8'd0, '0);
        add_cmd(OP_RELEASE, '0, '0, 32'd48, 0, 1);
        add_cmd(OP_RELEASE, '0, '0, 32'd16);
        add_cmd(OP_RELEASE, '0, '0, 32'd80);
        add_cmd(OP_RELEASE, '0, '0, 32'd20);

        run_phase(REGION_RESET, CHUNK_RESET, 0, 90, 50);
        run_phase(32'd65536, 8'd17, 75, 80, 85);     // mostly allocations, aimed at filling the live table
        run_phase(32'd64, 8'd17, 29, 50, 60);
        run_phase(32'hFFFF_FFFF, 8'd255, 75, 80, 55);
        run_phase(32'd4000, 8'd100, 0, 80, 50);
        run_phase(32'd2000, 8'd17, 29, 70, 55);

        // A region write alone must leave the tables as they are.
        wait_quiet();
        write_reg(CFG_REGION, 32'd512);
        idle_pct = 0;
        add_random(20, 50);

        wait_quiet();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ffca_pkg.sv
hdl/ffca_ram.sv
hdl/first_fit_coalescing_allocator.sv
sim/first_fit_coalescing_allocator_tb.sv
